// ----- hw/rtl/mcog_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcog_pkg: shared definitions for the midpoint circle outline generator
// Widths, register indexes, reset values and item codes used by all files.
// ----------------------------------------------------------------------------
package mcog_pkg;

  localparam int COORD_BITS_DEFAULT = 13;
  localparam int FRAME_BITS         = 13;
  localparam int DIAM_BITS          = 12;
  localparam int STEP_BITS          = 12;
  localparam int DEC_BITS           = 16;
  localparam int CFG_IDX_BITS       = 2;
  localparam int QUEUE_DEPTH        = 2;
  localparam int POINTS_PER_STEP    = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 13'd320;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 13'd240;

  // Item codes.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Decision variable constants of the midpoint update.
  localparam logic [DEC_BITS-1:0] DEC_INIT    = 16'd3;
  localparam logic [DEC_BITS-1:0] DEC_STEP_LE = 16'd6;
  localparam logic [DEC_BITS-1:0] DEC_STEP_GT = 16'd10;

  // Status of the step queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mcog_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcog_if: channel interfaces of the circle outline generator
// Input item channel, point result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface mcog_item_if #(
  parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEFAULT
);
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [COORD_BITS-1:0]     center_x;
  logic signed [COORD_BITS-1:0]     center_y;
  logic [mcog_pkg::DIAM_BITS-1:0]   diameter;

  modport source (output valid, mode, center_x, center_y, diameter, input ready);
  modport sink   (input valid, mode, center_x, center_y, diameter, output ready);
endinterface

interface mcog_point_if #(
  parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS:0]   point_x;
  logic signed [COORD_BITS:0]   point_y;
  logic                         inside_res;
  logic                         last;

  modport source (output valid, point_x, point_y, inside_res, last, input ready);
  modport sink   (input valid, point_x, point_y, inside_res, last, output ready);
endinterface

interface mcog_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mcog_pkg::CFG_IDX_BITS-1:0] index;
  logic [mcog_pkg::FRAME_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/midpoint_circle_outline_generator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_circle_outline_generator_core: midpoint circle rasterizer
// Turns start and advance items into the outline points of a circle.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one item per handshake. A start item (mode 0) latches the
//   center and diameter and produces no points. Each advance item (mode 1)
//   of an active circle yields eight mirrored octant points on pt_out, and
//   the eighth point of the final step has last set. An advance with no
//   circle active is taken and dropped.
//   cfg writes frame_width (index 0) and frame_height (index 1), which set
//   the inside_res flag of each point. Other indexes are ignored. Writes are
//   taken every cycle and are meant for idle periods only.
// Flow:
//   An accepted advance pushes its step record into the step queue; the back
//   then loads the points of the record one by one into its output register.
//   The point emitter puts out one point per cycle while pt_out is ready, so
//   it sets the sustained rate of advance items. A two-entry step queue lets
//   the front take further items while earlier steps are still being emitted.
// Reset and stalls:
//   rst (synchronous) ends any circle, empties the queue and restores the
//   frame size to 320 by 240. When pt_out is stalled the current point is
//   held; the queue fills and then item_in drops ready.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_generator_core #(
  parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mcog_item_if.sink    item_in,
  mcog_point_if.source pt_out,
  mcog_cfg_if.sink     cfg
);
  // One queued step: center, even offset, x, y before the update, final flag.
  localparam int REC_W = 2 * COORD_BITS + 2 * mcog_pkg::STEP_BITS + 2;

  logic [mcog_pkg::FRAME_BITS-1:0] frame_width;
  logic [mcog_pkg::FRAME_BITS-1:0] frame_height;

  logic                 push;
  logic [REC_W-1:0]     push_data;
  logic                 pop;
  logic [REC_W-1:0]     pop_data;
  mcog_pkg::q_status_t  q_status;

  // Configuration registers. The port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mcog_pkg::FRAME_WIDTH_RESET;
      frame_height <= mcog_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mcog_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
        mcog_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // The front owns the circle state and produces one step record per
  // accepted advance of an active circle.
  mcog_front #(
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  mcog_queue #(
    .WIDTH (REC_W),
    .DEPTH (mcog_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // The back expands each record into eight points through an output
  // register, so a stall on pt_out only holds the current point.
  mcog_back #(
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rec          (pop_data),
    .q_status     (q_status),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pop          (pop),
    .pt_out       (pt_out)
  );

  // The queue cannot report full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("step queue reports full and empty together");

  // A point can only appear after the queue held a step.
  a_point_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pt_out.valid) |-> $past(!q_status.empty))
    else $error("point emitted without a queued step");

  // No push is ever dropped by a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("step pushed into a full queue");

  // No point is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !pt_out.valid)
    else $error("point valid right after reset");
endmodule
`default_nettype wire

// ----- hw/rtl/mcog_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcog_queue: short step queue
// Register FIFO that decouples the step front end from the point back end.
// ----------------------------------------------------------------------------
module mcog_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcog_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output mcog_pkg::q_status_t   status
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mcog_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcog_front: item intake and midpoint stepper
// Accepts items, keeps the circle state and queues one record per step.
// ----------------------------------------------------------------------------
module mcog_front #(
  parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEFAULT,
  parameter int REC_W      = 2 * COORD_BITS + 2 * mcog_pkg::STEP_BITS + 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  mcog_item_if.sink              item_in,
  input  wire mcog_pkg::q_status_t q_status,
  output logic                   push,
  output logic [REC_W-1:0]       push_data
);
  localparam int SB = mcog_pkg::STEP_BITS;
  localparam int DB = mcog_pkg::DEC_BITS;

  logic [COORD_BITS-1:0] ctr_x;
  logic [COORD_BITS-1:0] ctr_y;
  logic                  even_offset;
  logic [SB-1:0]         step_x;
  logic [SB-1:0]         step_y;
  logic [DB-1:0]         decision;
  logic                  active;

  logic                  accept;
  logic                  dec_pos;
  logic [DB-1:0]         inc_le;
  logic [DB-1:0]         diff;
  logic [DB-1:0]         inc_gt;
  logic [DB-1:0]         decision_next;
  logic [SB+1:0]         x_plus1;
  logic [SB+1:0]         y_next;
  logic                  fin;
  logic [SB-2:0]         radius;

  assign item_in.ready = !q_status.full;
  assign accept        = item_in.valid && item_in.ready;
  assign push          = accept && (item_in.mode == mcog_pkg::MODE_ADVANCE) && active;

  // Midpoint update: the decision steps by 4x+6 when not positive, else by
  // 4(x-y)+10 with y moving one row inward.
  assign dec_pos       = !decision[DB-1] && (decision != '0);
  assign inc_le        = {{(DB-SB-2){1'b0}}, step_x, 2'b00} + mcog_pkg::DEC_STEP_LE;
  assign diff          = {{(DB-SB){1'b0}}, step_x} - {{(DB-SB){1'b0}}, step_y};
  assign inc_gt        = {diff[DB-3:0], 2'b00} + mcog_pkg::DEC_STEP_GT;
  assign decision_next = decision + (dec_pos ? inc_gt : inc_le);
  assign x_plus1       = {2'b00, step_x} + 1'b1;
  assign y_next        = {2'b00, step_y} - {{(SB+1){1'b0}}, dec_pos};
  assign fin           = $signed(x_plus1) > $signed(y_next);
  assign radius        = item_in.diameter[SB-1:1];

  assign push_data = {ctr_x, ctr_y, even_offset, step_x, step_y, fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      ctr_x       <= '0;
      ctr_y       <= '0;
      even_offset <= 1'b0;
      step_x      <= '0;
      step_y      <= '0;
      decision    <= '0;
    end else if (accept) begin
      if (item_in.mode == mcog_pkg::MODE_START) begin
        ctr_x       <= item_in.center_x;
        ctr_y       <= item_in.center_y;
        even_offset <= !item_in.diameter[0];
        step_x      <= '0;
        step_y      <= {1'b0, radius};
        decision    <= mcog_pkg::DEC_INIT - {{(DB-SB){1'b0}}, radius, 1'b0};
        active      <= 1'b1;
      end else if (active) begin
        decision <= decision_next;
        step_x   <= x_plus1[SB-1:0];
        step_y   <= y_next[SB-1:0];
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mcog_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcog_back: octant point emitter
// Turns each queued step into eight mirrored points, one per unstalled cycle.
// ----------------------------------------------------------------------------
module mcog_back #(
  parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEFAULT,
  parameter int REC_W      = 2 * COORD_BITS + 2 * mcog_pkg::STEP_BITS + 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [REC_W-1:0]                rec,
  input  wire mcog_pkg::q_status_t             q_status,
  input  wire logic [mcog_pkg::FRAME_BITS-1:0] frame_width,
  input  wire logic [mcog_pkg::FRAME_BITS-1:0] frame_height,
  output logic                                 pop,
  mcog_point_if.source                         pt_out
);
  localparam int SB    = mcog_pkg::STEP_BITS;
  localparam int FB    = mcog_pkg::FRAME_BITS;
  localparam int SUM_W = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;
  localparam int IDX_W = $clog2(mcog_pkg::POINTS_PER_STEP);

  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic                  e;
  logic [SB-1:0]         sx;
  logic [SB-1:0]         sy;
  logic                  fin;

  logic [IDX_W-1:0]      idx;
  logic                  load;
  logic                  last_pt;
  logic [SUM_W-1:0]      cx_w;
  logic [SUM_W-1:0]      cy_w;
  logic [SUM_W-1:0]      e_w;
  logic [SUM_W-1:0]      a_w;
  logic [SUM_W-1:0]      b_w;
  logic [SUM_W-1:0]      px;
  logic [SUM_W-1:0]      py;
  logic                  in_frame;

  logic                  out_valid;
  logic [COORD_BITS:0]   point_x;
  logic [COORD_BITS:0]   point_y;
  logic                  inside_res;
  logic                  last;

  assign {cx, cy, e, sx, sy, fin} = rec;

  assign load    = !q_status.empty && (!out_valid || pt_out.ready);
  assign last_pt = (idx == IDX_W'(mcog_pkg::POINTS_PER_STEP - 1));
  assign pop     = load && last_pt;

  // The upper four points swap the roles of x and y; bit 0 mirrors the
  // column and bit 1 mirrors the row about the center.
  assign cx_w = {{(SUM_W-COORD_BITS){cx[COORD_BITS-1]}}, cx};
  assign cy_w = {{(SUM_W-COORD_BITS){cy[COORD_BITS-1]}}, cy};
  assign e_w  = {{(SUM_W-1){1'b0}}, e};
  assign a_w  = {{(SUM_W-SB){1'b0}}, (idx[2] ? sy : sx)};
  assign b_w  = {{(SUM_W-SB){1'b0}}, (idx[2] ? sx : sy)};
  assign px   = idx[0] ? (cx_w + e_w - a_w) : (cx_w + a_w);
  assign py   = idx[1] ? (cy_w + e_w - b_w) : (cy_w + b_w);

  assign in_frame = !px[SUM_W-1] && !py[SUM_W-1] &&
                    (px < {{(SUM_W-FB){1'b0}}, frame_width}) &&
                    (py < {{(SUM_W-FB){1'b0}}, frame_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pt_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point_x    <= px[COORD_BITS:0];
      point_y    <= py[COORD_BITS:0];
      inside_res <= in_frame;
      last       <= fin && last_pt;
    end
  end

  assign pt_out.valid      = out_valid;
  assign pt_out.point_x    = point_x;
  assign pt_out.point_y    = point_y;
  assign pt_out.inside_res = inside_res;
  assign pt_out.last       = last;
endmodule
`default_nettype wire

// ----- tb/tb_midpoint_circle_outline_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_outline_generator_core: self-checking bench
// Drives start and advance items and frame size writes into the circle
// rasterizer, predicts every outline point, and checks the points in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_outline_generator_core;

  localparam int CB            = mcog_pkg::COORD_BITS_DEFAULT;
  localparam int PB            = CB + 1;
  localparam int FB            = mcog_pkg::FRAME_BITS;
  localparam int SB            = mcog_pkg::STEP_BITS;
  localparam int DECB          = mcog_pkg::DEC_BITS;
  localparam int DIAMB         = mcog_pkg::DIAM_BITS;
  localparam int IDXB          = mcog_pkg::CFG_IDX_BITS;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 40000;
  localparam int LONG_STALL    = 150;
  localparam int RANDOM_ITEMS  = 24;

  // Register indexes that map to no register; writes to them must be dropped.
  localparam logic [IDXB-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [IDXB-1:0] CFG_UNUSED_HI = 2'd3;

  typedef struct packed {
    logic signed [PB-1:0] x;
    logic signed [PB-1:0] y;
    logic                 in_frame;
    logic                 last;
  } outline_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcog_item_if  #(.COORD_BITS(CB)) item_if ();
  mcog_point_if #(.COORD_BITS(CB)) pt_if ();
  mcog_cfg_if                      cfg_if ();

  midpoint_circle_outline_generator_core #(.COORD_BITS(CB)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_if),
    .pt_out  (pt_if),
    .cfg     (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the frame size and of the circle being rasterized.
  logic [FB-1:0]          frame_w = mcog_pkg::FRAME_WIDTH_RESET;
  logic [FB-1:0]          frame_h = mcog_pkg::FRAME_HEIGHT_RESET;
  logic signed [CB-1:0]   circ_cx = '0;
  logic signed [CB-1:0]   circ_cy = '0;
  logic                   circ_even = 1'b0;
  logic [SB-1:0]          circ_x = '0;
  logic [SB-1:0]          circ_y = '0;
  logic signed [DECB-1:0] circ_dec = '0;
  logic                   circ_active = 1'b0;

  // Points still owed by the block, oldest first.
  outline_point_t expected_points[$];
  outline_point_t want;

  // Knobs shared between the test tasks and the receiver process.
  logic tx_no_gaps      = 1'b0;
  logic rx_always_ready = 1'b0;
  logic stall_req       = 1'b0;
  int   stall_left      = 0;
  int   rx_off_left     = 0;
  int   rx_roll;

  int errors         = 0;
  int n_starts       = 0;
  int n_advances     = 0;
  int n_ignored      = 0;
  int n_points       = 0;
  int n_writes       = 0;
  int n_input_stalls = 0;

  // Queue one expected point; the in-frame flag uses the frame size in force
  // when the advance item is taken, since writes only happen while idle.
  function automatic void expect_point(int px, int py, logic last_flag);
    outline_point_t p;
    p.x        = px[PB-1:0];
    p.y        = py[PB-1:0];
    p.in_frame = (px >= 0) && (py >= 0) && (px < int'(frame_w)) && (py < int'(frame_h));
    p.last     = last_flag;
    expected_points.push_back(p);
  endfunction

  // Midpoint circle step: a start loads the circle, an advance on a live
  // circle emits the eight mirrored points and updates the decision term.
  function automatic void rasterize_item(logic mode, logic signed [CB-1:0] cx,
                                         logic signed [CB-1:0] cy,
                                         logic [DIAMB-1:0] d);
    int r, x, y, y0, e, ox, oy, nd, nx;
    logic fin;
    if (mode == mcog_pkg::MODE_START) begin
      r           = int'(d) >> 1;
      circ_cx     = cx;
      circ_cy     = cy;
      circ_even   = ~d[0];
      circ_x      = '0;
      circ_y      = r[SB-1:0];
      nd          = int'(mcog_pkg::DEC_INIT) - 2 * r;
      circ_dec    = nd[DECB-1:0];
      circ_active = 1'b1;
    end else if (circ_active) begin
      x  = int'(circ_x);
      y0 = int'(circ_y);
      y  = y0;
      e  = circ_even ? 1 : 0;
      ox = int'(circ_cx);
      oy = int'(circ_cy);
      if (circ_dec <= 0) begin
        nd = int'(circ_dec) + 4 * x + int'(mcog_pkg::DEC_STEP_LE);
      end else begin
        nd = int'(circ_dec) + 4 * (x - y) + int'(mcog_pkg::DEC_STEP_GT);
        y  = y - 1;
      end
      circ_dec = nd[DECB-1:0];
      fin      = (x + 1) > y;
      // Points use the row from before the update, in octant order.
      expect_point(ox + x,      oy + y0,     1'b0);
      expect_point(ox + e - x,  oy + y0,     1'b0);
      expect_point(ox + x,      oy + e - y0, 1'b0);
      expect_point(ox + e - x,  oy + e - y0, 1'b0);
      expect_point(ox + y0,     oy + x,      1'b0);
      expect_point(ox + e - y0, oy + x,      1'b0);
      expect_point(ox + y0,     oy + e - x,  1'b0);
      expect_point(ox + e - y0, oy + e - x,  fin);
      nx     = x + 1;
      circ_x = nx[SB-1:0];
      circ_y = y[SB-1:0];
      if (fin) begin
        circ_active = 1'b0;
      end
    end
  endfunction

  // Sender gap: mostly back to back or short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (tx_no_gaps) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 50);
  endfunction

  // Offer one item at the falling edge and hold it until it is taken. Valid
  // stays high when no gap follows, so the next item goes out without a dip.
  task automatic send_item(input logic mode, input logic signed [CB-1:0] cx,
                           input logic signed [CB-1:0] cy,
                           input logic [DIAMB-1:0] d);
    int gap;
    @(negedge clk);
    item_if.valid    <= 1'b1;
    item_if.mode     <= mode;
    item_if.center_x <= cx;
    item_if.center_y <= cy;
    item_if.diameter <= d;
    @(posedge clk);
    while (!item_if.ready) begin
      n_input_stalls++;
      @(posedge clk);
    end
    if (mode == mcog_pkg::MODE_START) begin
      n_starts++;
    end else if (circ_active) begin
      n_advances++;
    end else begin
      n_ignored++;
    end
    rasterize_item(mode, cx, cy, d);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic start_circle(input int cx, input int cy, input int d);
    send_item(mcog_pkg::MODE_START, cx[CB-1:0], cy[CB-1:0], d[DIAMB-1:0]);
  endtask

  // The center and diameter fields of an advance are don't-care; fill them
  // with noise so the block is seen to ignore them.
  task automatic advance();
    send_item(mcog_pkg::MODE_ADVANCE, CB'($urandom), CB'($urandom), DIAMB'($urandom));
  endtask

  task automatic run_circle(input int cx, input int cy, input int d);
    start_circle(cx, cy, d);
    while (circ_active) begin
      advance();
    end
  endtask

  // Drop valid, wait for every owed point, then let the pipeline empty.
  task automatic settle_block();
    int waited;
    @(negedge clk);
    item_if.valid <= 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      errors++;
      expected_points.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXB-1:0] idx,
                           input logic [FB-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    if (idx == mcog_pkg::CFG_FRAME_WIDTH) begin
      frame_w = val;
    end else if (idx == mcog_pkg::CFG_FRAME_HEIGHT) begin
      frame_h = val;
    end
    n_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    settle_block();
    write_reg(mcog_pkg::CFG_FRAME_WIDTH, w[FB-1:0]);
    write_reg(mcog_pkg::CFG_FRAME_HEIGHT, h[FB-1:0]);
  endtask

  // Circles that straddle the edges of the 320 by 240 frame left by reset.
  task automatic test_reset_frame();
    run_circle(318, 238, 5);
    run_circle(1, 1, 4);
  endtask

  // Short directed list: idle advances, the degenerate diameters, the
  // coordinate and diameter extremes, and a restart over a live circle.
  task automatic test_directed();
    advance();
    start_circle(0, 0, 0);
    advance();
    advance();
    start_circle(-1, -1, 1);
    advance();
    start_circle(4095, -4096, 4095);
    repeat (3) advance();
    start_circle(-4096, 4095, 4094);
    repeat (2) advance();
    start_circle(5, 5, 10);
    repeat (2) advance();
    run_circle(100, 100, 7);
    advance();
  endtask

  // Frame sizes at the corners of their range, including zero where no
  // point can be inside and all ones in the data field.
  task automatic test_frame_sizes();
    set_frame(0, 0);
    run_circle(2, 2, 6);
    set_frame(1, 1);
    run_circle(0, 0, 2);
    set_frame(4096, 4096);
    run_circle(4090, 4090, 12);
    run_circle(-3, 4093, 8);
    set_frame(8191, 8191);
    run_circle(4095, 4095, 20);
    set_frame(1, 4096);
    run_circle(0, 100, 9);
    // Writes to unmapped indexes must leave the frame size alone.
    settle_block();
    write_reg(CFG_UNUSED_LO, 13'h1FFF);
    write_reg(CFG_UNUSED_HI, 13'h0000);
    run_circle(0, 0, 6);
    set_frame(int'(mcog_pkg::FRAME_WIDTH_RESET), int'(mcog_pkg::FRAME_HEIGHT_RESET));
  endtask

  // Both sides at full rate: the emitter alone paces the items.
  task automatic test_full_rate();
    tx_no_gaps      = 1'b1;
    rx_always_ready = 1'b1;
    run_circle(160, 120, 48);
    run_circle(-2, 3, 3);
    tx_no_gaps      = 1'b0;
    rx_always_ready = 1'b0;
    settle_block();
  endtask

  // The receiver holds off while advances keep coming, so the step queue
  // fills and the input side has to stall.
  task automatic test_backpressure();
    stall_req  = 1'b1;
    tx_no_gaps = 1'b1;
    start_circle(50, 50, 90);
    repeat (20) advance();
    tx_no_gaps = 1'b0;
    settle_block();
  endtask

  // Random circles, mostly run to completion, some cut short by a new start
  // and a few stray advances, over three rounds of frame sizes.
  task automatic test_random();
    int chunk, goal, roll, span, cx, cy, d, steps;
    logic big;
    for (chunk = 0; chunk < 3; chunk++) begin
      case (chunk)
        0: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
        1: set_frame($urandom_range(1, 64), $urandom_range(1, 64));
        default: set_frame($urandom_range(0, 8191), $urandom_range(0, 8191));
      endcase
      goal = n_starts + n_advances + RANDOM_ITEMS / 3;
      while (n_starts + n_advances < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          advance();
        end else begin
          roll = $urandom_range(0, 99);
          big  = 1'b0;
          if (roll < 70) begin
            d = $urandom_range(0, 24);
          end else if (roll < 95) begin
            d = $urandom_range(25, 160);
          end else begin
            d   = $urandom_range(1000, 4095);
            big = 1'b1;
          end
          if ($urandom_range(0, 99) < 75) begin
            span = (frame_w > 4000) ? 4000 : int'(frame_w);
            cx   = int'($urandom_range(0, span + 60)) - 30;
            span = (frame_h > 4000) ? 4000 : int'(frame_h);
            cy   = int'($urandom_range(0, span + 60)) - 30;
          end else begin
            cx = $urandom_range(0, 8191);
            cy = $urandom_range(0, 8191);
          end
          start_circle(cx, cy, d);
          if (big) begin
            steps = $urandom_range(1, 6);
          end else if ($urandom_range(0, 99) < 85) begin
            steps = 1 << 20;
          end else begin
            steps = $urandom_range(1, 8);
          end
          while (circ_active && steps > 0) begin
            advance();
            steps--;
          end
        end
      end
    end
  endtask

  // Receiver: ready changes at the falling edge. A requested long stall wins,
  // then the full-rate knob, then random short and occasional long gaps.
  always @(negedge clk) begin
    if (stall_req) begin
      stall_left = LONG_STALL;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      pt_if.ready <= 1'b0;
      stall_left--;
    end else if (rx_always_ready) begin
      pt_if.ready <= 1'b1;
    end else if (rx_off_left > 0) begin
      pt_if.ready <= 1'b0;
      rx_off_left--;
    end else begin
      pt_if.ready <= 1'b1;
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 20) begin
        rx_off_left = $urandom_range(1, 3);
      end else if (rx_roll < 23) begin
        rx_off_left = $urandom_range(15, 50);
      end
    end
  end

  // Every point taken at a rising edge is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && pt_if.valid && pt_if.ready) begin
      if (expected_points.size() == 0) begin
        $error("point (%0d, %0d) arrived with none expected", pt_if.point_x, pt_if.point_y);
        errors++;
      end else begin
        want = expected_points.pop_front();
        n_points++;
        if (pt_if.point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, pt_if.point_x);
          errors++;
        end
        if (pt_if.point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, pt_if.point_y);
          errors++;
        end
        if (pt_if.inside_res !== want.in_frame) begin
          $error("inside_res: expected %0b, got %0b", want.in_frame, pt_if.inside_res);
          errors++;
        end
        if (pt_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, pt_if.last);
          errors++;
        end
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5000000;
    $display("tb_midpoint_circle_outline_generator_core failed");
    $finish;
  end

  initial begin
    item_if.valid    = 1'b0;
    item_if.mode     = mcog_pkg::MODE_START;
    item_if.center_x = '0;
    item_if.center_y = '0;
    item_if.diameter = '0;
    pt_if.ready      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = mcog_pkg::CFG_FRAME_WIDTH;
    cfg_if.data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_frame();
    test_directed();
    test_frame_sizes();
    test_full_rate();
    test_backpressure();
    test_random();
    settle_block();

    $display("Covered %0d starts, %0d live advances, %0d idle advances; %0d points checked.",
             n_starts, n_advances, n_ignored, n_points);
    $display("%0d register writes across edge and random frame sizes; %0d input stall cycles.",
             n_writes, n_input_stalls);
    if (errors == 0) begin
      $display("tb_midpoint_circle_outline_generator_core passed");
    end else begin
      $display("tb_midpoint_circle_outline_generator_core failed");
    end
    $finish;
  end

endmodule
